>>> rtl/hqp_pkg.sv
// Shared constants, types and the Gray-code rank function for the Hall quadrature positioner.
`default_nettype none

package hqp_pkg;

  // Default width of the position and target counters.
  localparam int unsigned POSITION_WIDTH_DEF = 32;

  // Fixed widths of the port fields.
  localparam int unsigned HALL_W  = 2;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned DRIVE_W = 2;
  localparam int unsigned STEP_W  = 2;

  typedef logic [HALL_W-1:0]         hall_t;
  typedef logic [HALL_W-1:0]         rank_t;
  typedef logic [TOL_W-1:0]          tol_t;
  typedef logic [DRIVE_W-1:0]        drive_t;
  typedef logic signed [STEP_W-1:0]  step_t;
  typedef logic signed [FIELD_W-1:0] field_t;

  localparam tol_t TOL_RESET = 16'd5;

  // Motor commands.
  localparam drive_t DRIVE_STOP = 2'd0;
  localparam drive_t DRIVE_UP   = 2'd1;
  localparam drive_t DRIVE_DOWN = 2'd2;

  // Count steps.
  localparam step_t STEP_NONE = 2'sb00;
  localparam step_t STEP_FWD  = 2'sb01;
  localparam step_t STEP_BACK = 2'sb11;

  // Rank differences (mod 4) between two samples.
  localparam rank_t RANK_DIFF_FWD  = 2'd1;
  localparam rank_t RANK_DIFF_BACK = 2'd3;

  // Gray order 00 -> 01 -> 11 -> 10.
  function automatic rank_t hqp_rank(input hall_t bits);
    rank_t r;
    case (bits)
      2'b00: r = 2'd0;
      2'b01: r = 2'd1;
      2'b11: r = 2'd2;
      2'b10: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hall_quadrature_positioner_core.sv
// Top level of the Hall quadrature positioner: sample register, decode, count and drive compare.
`default_nettype none

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+---------------------------------------------
// in_       | input     | in_valid / in_ready   | hall_bits, zero_request, load_target,
//           |           |                       | new_target
// out_      | output    | out_valid / out_ready | position, target, drive, count_step
// cfg_      | input     | cfg_we (no wait)      | cfg_wdata = tolerance
//
// One sample per cycle sustained while the output is not stalled. A transfer lands in the
// sample register, and is then decoded and its result loaded into the result register,
// which offers it on the output channel.
// The counter state advances only when a sample moves into the result register;
// a stalled output holds both stages and drops in_ready once both are full.
// rst_n is synchronous, active low: position, target, rank and tolerance (5) reset.
module hall_quadrature_positioner_core #(
  parameter int unsigned POSITION_WIDTH = hqp_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire hqp_pkg::hall_t        in_hall_bits,
  input  wire logic                  in_zero_request,
  input  wire logic                  in_load_target,
  input  wire hqp_pkg::field_t       in_new_target,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      hqp_pkg::field_t       out_position,
  output      hqp_pkg::field_t       out_target,
  output      hqp_pkg::drive_t       out_drive,
  output      hqp_pkg::step_t        out_count_step,
  // configuration
  input  wire logic                  cfg_we,
  input  wire hqp_pkg::tol_t         cfg_wdata
);
  import hqp_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  // Compare width: room for the difference of two PW values and for the tolerance.
  localparam int unsigned CW = ((PW > TOL_W) ? PW : TOL_W) + 2;

  typedef logic signed [PW-1:0] pos_t;
  typedef logic signed [CW-1:0] cmp_t;

  // Sample register.
  logic   s1_v_r;
  hall_t  s1_hall_r;
  logic   s1_zero_r;
  logic   s1_load_r;
  field_t s1_tgt_r;

  // Counter state.
  pos_t   pos_r;
  pos_t   tgt_r;
  rank_t  last_rank_r;
  logic   rank_seen_r;
  tol_t   tol_r;

  // Result register.
  logic   out_v_r;
  field_t out_pos_r;
  field_t out_tgt_r;
  drive_t out_drive_r;
  step_t  out_step_r;

  // Decode of the held sample.
  logic   advance;
  pos_t   pos_base;
  pos_t   pos_nxt;
  pos_t   tgt_nxt;
  rank_t  rank;
  rank_t  rank_diff;
  step_t  step;
  cmp_t   diff;
  cmp_t   tol_ext;
  drive_t drive_nxt;

  // Move the sample on when the result register is empty or being drained.
  assign advance  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || advance;

  always_comb begin
    // Zero first, then load the new target.
    pos_base = s1_zero_r ? '0 : pos_r;
    if (s1_load_r) begin
      tgt_nxt = PW'(s1_tgt_r);
    end else if (s1_zero_r) begin
      tgt_nxt = '0;
    end else begin
      tgt_nxt = tgt_r;
    end

    rank      = hqp_rank(s1_hall_r);
    rank_diff = rank - last_rank_r;
    step      = STEP_NONE;
    // The first sample only seeds the rank; a jump of two counts nothing.
    if (rank_seen_r) begin
      case (rank_diff)
        RANK_DIFF_FWD:  step = STEP_FWD;
        RANK_DIFF_BACK: step = STEP_BACK;
        default:        step = STEP_NONE;
      endcase
    end
    pos_nxt = pos_base + PW'(step);

    // Full-width signed compare, no wrap: up below the deadband, down above it.
    diff    = CW'(tgt_nxt) - CW'(pos_nxt);
    tol_ext = CW'($signed({1'b0, tol_r}));
    if (diff > tol_ext) begin
      drive_nxt = DRIVE_UP;
    end else if (diff < -tol_ext) begin
      drive_nxt = DRIVE_DOWN;
    end else begin
      drive_nxt = DRIVE_STOP;
    end
  end

  // Sample register: load on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_hall_r <= in_hall_bits;
      s1_zero_r <= in_zero_request;
      s1_load_r <= in_load_target;
      s1_tgt_r  <= in_new_target;
    end
  end

  // Counter state and tolerance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      tgt_r       <= '0;
      last_rank_r <= '0;
      rank_seen_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      if (advance) begin
        pos_r       <= pos_nxt;
        tgt_r       <= tgt_nxt;
        last_rank_r <= rank;
        rank_seen_r <= 1'b1;
      end
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  // Result register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
    if (advance) begin
      out_pos_r   <= FIELD_W'(pos_nxt);
      out_tgt_r   <= FIELD_W'(tgt_nxt);
      out_drive_r <= drive_nxt;
      out_step_r  <= step;
    end
  end

  assign out_valid      = out_v_r;
  assign out_position   = out_pos_r;
  assign out_target     = out_tgt_r;
  assign out_drive      = out_drive_r;
  assign out_count_step = out_step_r;

  // A counted step without a zero request always moves the position.
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_zero_r && step != STEP_NONE) |=> (pos_r != $past(pos_r)))
    else $error("counted step left position unchanged");

  // Drive up only while the position lies below the target.
  a_up_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_drive_r == DRIVE_UP) |-> (pos_r < tgt_r))
    else $error("drive up with position not below target");

  // Drive down only while the position lies above the target.
  a_down_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_drive_r == DRIVE_DOWN) |-> (pos_r > tgt_r))
    else $error("drive down with position not above target");

  // A held sample stays put while the result register is full and stalled.
  a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |=> (s1_v_r && $stable(s1_hall_r) && $stable(s1_tgt_r)))
    else $error("stalled sample register changed");

endmodule

`default_nettype wire
